@@ design/lru_pkg.sv @@
package lru_pkg;

  localparam int unsigned NUM_FRAMES = 16;
  localparam int unsigned FRAME_W    = 4;
  localparam int unsigned OCC_W      = $clog2(NUM_FRAMES + 1);

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [OCC_W-1:0]   occ_t;

  typedef enum logic [0:0] {
    CMD_ACCESS = 1'b0,
    CMD_EVICT  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic valid;
    logic fill;
    logic tail;
  } cell_ctrl_t;

  typedef struct packed {
    logic   hit;
    frame_t tail;
  } chain_t;

endpackage

@@ design/lru_if.sv @@
interface lru_cmd_if;
  logic            valid;
  logic            ready;
  lru_pkg::cmd_e   command;
  lru_pkg::frame_t frame;

  modport source (output valid, output command, output frame, input ready);
  modport sink   (input valid, input command, input frame, output ready);
endinterface

interface lru_res_if;
  logic            valid;
  logic            ready;
  lru_pkg::frame_t victim_frame;
  logic            victim_valid;
  logic            stack_empty;

  modport source (output valid, output victim_frame, output victim_valid,
                  output stack_empty, input ready);
  modport sink   (input valid, input victim_frame, input victim_valid,
                  input stack_empty, output ready);
endinterface

@@ design/lru_frame_replacement_unit.sv @@
// Result: registered, and presented in the cycle after the command is accepted.
// Throughput: one command per cycle while res_o.ready holds; the cell chain resolves
//   a lookup, shift and tail read in a single pass, and a result register decouples.
// Reset: occupancy and result valid clear; frame entries are not reset
//   and become meaningful only as frames are inserted.
module lru_frame_replacement_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  lru_cmd_if.sink   cmd_i,
  lru_res_if.source res_o
);
  import lru_pkg::*;

  occ_t       occ_q;
  occ_t       occ_d;
  logic       out_valid_q;
  frame_t     victim_frame_q;
  logic       victim_valid_q;
  logic       stack_empty_q;

  logic       accept;
  logic       access;
  logic       evict;
  logic       in_range;
  logic       full;
  logic       empty;
  logic       hit_any;
  logic       update;

  frame_t     entry   [NUM_FRAMES];
  chain_t     chain   [NUM_FRAMES+1];
  cell_ctrl_t ctrl    [NUM_FRAMES];

  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign access      = accept && (cmd_i.command == CMD_ACCESS);
  assign evict       = accept && (cmd_i.command == CMD_EVICT);
  assign in_range    = 32'(cmd_i.frame) < NUM_FRAMES;
  assign full        = occ_q == OCC_W'(NUM_FRAMES);
  assign empty       = occ_q == '0;
  assign hit_any     = chain[NUM_FRAMES].hit;
  assign update      = access && in_range && (hit_any || !full);

  assign chain[0].hit  = 1'b0;
  assign chain[0].tail = '0;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    assign ctrl[i].valid = OCC_W'(i) < occ_q;
    assign ctrl[i].fill  = OCC_W'(i) == occ_q;
    assign ctrl[i].tail  = OCC_W'(i + 1) == occ_q;

    lru_cell u_cell (
      .clk_i        (clk_i),
      .update_i     (update),
      .frame_i      (cmd_i.frame),
      .ctrl_i       (ctrl[i]),
      .prev_entry_i ((i == 0) ? cmd_i.frame : entry[(i == 0) ? 0 : i - 1]),
      .chain_i      (chain[i]),
      .entry_o      (entry[i]),
      .chain_o      (chain[i+1])
    );
  end

  always_comb begin
    occ_d = occ_q;
    if (update && !hit_any) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (evict && !empty) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      victim_frame_q <= (evict && !empty) ? chain[NUM_FRAMES].tail : '0;
      victim_valid_q <= evict && !empty;
      stack_empty_q  <= evict && empty;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.victim_frame = victim_frame_q;
  assign res_o.victim_valid = victim_valid_q;
  assign res_o.stack_empty  = stack_empty_q;

endmodule

@@ design/lru_cell.sv @@
module lru_cell (
  input  logic                clk_i,
  input  logic                update_i,
  input  lru_pkg::frame_t     frame_i,
  input  lru_pkg::cell_ctrl_t ctrl_i,
  input  lru_pkg::frame_t     prev_entry_i,
  input  lru_pkg::chain_t     chain_i,
  output lru_pkg::frame_t     entry_o,
  output lru_pkg::chain_t     chain_o
);
  import lru_pkg::*;

  frame_t entry_q;
  frame_t entry_d;
  logic   own_hit;
  logic   load;

  assign own_hit = ctrl_i.valid && (entry_q == frame_i);
  assign load    = update_i && !chain_i.hit && (ctrl_i.valid || ctrl_i.fill);

  always_comb begin
    entry_d = entry_q;
    if (load) begin
      entry_d = prev_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o      = entry_q;
  assign chain_o.hit  = chain_i.hit || own_hit;
  assign chain_o.tail = ctrl_i.tail ? entry_q : chain_i.tail;

endmodule
